/* rtl/rbst_pkg.sv */
package rbst_pkg;

  // Per-axis zero-extent flags carried alongside the dividers to the min/max and reduction stages
  typedef struct packed {
    logic unbounded;  // zero extent along this axis
    logic miss;       // zero extent, start outside the slab
  } axis_flags_t;

endpackage

/* rtl/rbst_fixdiv.sv */
// Pipelined restoring divider: ((|num| << FRAC_BITS) / |den|), one quotient
// bit per stage, then sign and saturation. A magnitude stage, NB stages and an output stage.
module rbst_fixdiv #(
  parameter int NW = 34,
  parameter int DW = 33,
  parameter int FRAC_BITS = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [NW-1:0]          num_i,
  input  logic signed [DW-1:0]          den_i,
  output logic signed [COORD_WIDTH-1:0] q_o
);
  localparam int NB = NW + FRAC_BITS;
  localparam int QW = NB;
  localparam int RW = DW + 1;

  logic [NB-1:0] n_q [NB+1];
  logic [DW-1:0] d_q [NB+1];
  logic [RW-1:0] r_q [NB+1];
  logic [QW-1:0] qq_q [NB+1];
  logic          neg_q [NB+1];

  logic [NW-1:0] nmag;
  logic [DW-1:0] dmag;
  assign nmag = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
  assign dmag = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);

  // stage 0: magnitudes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]   <= {nmag, {FRAC_BITS{1'b0}}};
      d_q[0]   <= dmag;
      r_q[0]   <= '0;
      qq_q[0]  <= '0;
      neg_q[0] <= num_i[NW-1] ^ den_i[DW-1];
    end
  end

  // one quotient bit per stage
  for (genvar g = 0; g < NB; g++) begin : g_stage
    logic [RW-1:0] rs;
    logic          ge;
    assign rs = {r_q[g][RW-2:0], n_q[g][NB-1-g]};
    assign ge = rs >= {1'b0, d_q[g]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[g+1]   <= n_q[g];
        d_q[g+1]   <= d_q[g];
        r_q[g+1]   <= ge ? rs - {1'b0, d_q[g]} : rs;
        qq_q[g+1]  <= {qq_q[g][QW-2:0], ge};
        neg_q[g+1] <= neg_q[g];
      end
    end
  end

  // saturate and sign
  localparam logic [QW-1:0] CAP = QW'(1) << (COORD_WIDTH - 1);
  logic [QW-1:0] qm;
  always_comb begin
    qm = qq_q[NB];
    if (qm > CAP) qm = CAP;
    if (!neg_q[NB] && qm == CAP) qm = CAP - QW'(1);
  end
  always_ff @(posedge clk_i) begin
    if (en_i) q_o <= neg_q[NB] ? COORD_WIDTH'(-qm) : COORD_WIDTH'(qm);
  end
endmodule

/* rtl/ray_box_slab_test.sv */
// Ray versus axis-aligned box slab test over the infinite line.
// Input channel: twelve signed coordinates (start, end, box lo, box hi)
// with in_valid_i / in_stall_o; a beat is taken when valid is high and
// stall is low. Output channel: hit_o with out_valid_o / out_stall_i.
// Throughput: one beat per cycle while the output is not stalled. The
// path from the accepting edge to out_valid_o runs through the six
// bit-per-stage pipelined dividers.
// Stage A forms differences, the dividers produce slab parameters, then
// min/max per axis, then the entry/exit reduction and compare.
// An output stall while the last stage holds a beat freezes the whole
// pipeline, and the input is stalled exactly then, so nothing is lost.
// Reset clears valid bits only; data registers are not reset.
module ray_box_slab_test
  import rbst_pkg::*;
#(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] start_x_i,
  input  logic signed [COORD_WIDTH-1:0] start_y_i,
  input  logic signed [COORD_WIDTH-1:0] start_z_i,
  input  logic signed [COORD_WIDTH-1:0] end_x_i,
  input  logic signed [COORD_WIDTH-1:0] end_y_i,
  input  logic signed [COORD_WIDTH-1:0] end_z_i,
  input  logic signed [COORD_WIDTH-1:0] box_lo_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_lo_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_lo_z_i,
  input  logic signed [COORD_WIDTH-1:0] box_hi_x_i,
  input  logic signed [COORD_WIDTH-1:0] box_hi_y_i,
  input  logic signed [COORD_WIDTH-1:0] box_hi_z_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic hit_o
);
  localparam int CW  = COORD_WIDTH;
  localparam int NW  = CW + 2;
  localparam int DW  = CW + 1;
  localparam int DL  = NW + FRAC_BITS + 2;  // divider latency
  localparam int LAT = DL + 4;               // total valid pipe length

  logic en;
  logic [LAT-1:0] vld_q;
  assign en = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o = !en;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  logic signed [CW-1:0] s_in [3], e_in [3], lo_in [3], hi_in [3];
  assign s_in  = '{start_x_i, start_y_i, start_z_i};
  assign e_in  = '{end_x_i, end_y_i, end_z_i};
  assign lo_in = '{box_lo_x_i, box_lo_y_i, box_lo_z_i};
  assign hi_in = '{box_hi_x_i, box_hi_y_i, box_hi_z_i};

  axis_flags_t fl_q [3][DL+2];
  logic signed [CW-1:0] tn_q [3], tx_q [3];
  logic signed [CW-1:0] ent_q, ext_q;
  logic any_miss_q;
  logic hit_q;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [NW-1:0] n0_q, n1_q;
    logic signed [DW-1:0] d_q;
    logic signed [CW-1:0] t0, t1;
    logic signed [CW-1:0] smin, smax;
    assign smin = (lo_in[a] < hi_in[a]) ? lo_in[a] : hi_in[a];
    assign smax = (lo_in[a] < hi_in[a]) ? hi_in[a] : lo_in[a];

    // stage A: differences and zero-extent flags
    always_ff @(posedge clk_i) begin
      if (en) begin
        n0_q <= NW'(lo_in[a]) - NW'(s_in[a]);
        n1_q <= NW'(hi_in[a]) - NW'(s_in[a]);
        d_q  <= DW'(e_in[a]) - DW'(s_in[a]);
        fl_q[a][0].unbounded <= (e_in[a] == s_in[a]);
        fl_q[a][0].miss <= (e_in[a] == s_in[a]) &&
                           (s_in[a] < smin || s_in[a] > smax);
      end
    end

    for (genvar k = 0; k < DL + 1; k++) begin : g_fl
      always_ff @(posedge clk_i) begin
        if (en) fl_q[a][k+1] <= fl_q[a][k];
      end
    end

    // zero divisor gives garbage; the unbounded flag masks it
    rbst_fixdiv #(.NW(NW), .DW(DW), .FRAC_BITS(FRAC_BITS), .COORD_WIDTH(CW))
      u_div0 (.clk_i, .en_i(en), .num_i(n0_q), .den_i(d_q), .q_o(t0));
    rbst_fixdiv #(.NW(NW), .DW(DW), .FRAC_BITS(FRAC_BITS), .COORD_WIDTH(CW))
      u_div1 (.clk_i, .en_i(en), .num_i(n1_q), .den_i(d_q), .q_o(t1));

    // per-axis min/max, unbounded axes open wide
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (fl_q[a][DL].unbounded) begin
          tn_q[a] <= {1'b1, {(CW-1){1'b0}}};
          tx_q[a] <= {1'b0, {(CW-1){1'b1}}};
        end else begin
          tn_q[a] <= (t0 < t1) ? t0 : t1;
          tx_q[a] <= (t0 < t1) ? t1 : t0;
        end
      end
    end
  end

  // entry / exit reduction
  logic signed [CW-1:0] en01, ex01;
  assign en01 = (tn_q[0] > tn_q[1]) ? tn_q[0] : tn_q[1];
  assign ex01 = (tx_q[0] < tx_q[1]) ? tx_q[0] : tx_q[1];
  always_ff @(posedge clk_i) begin
    if (en) begin
      ent_q <= (tn_q[2] > en01) ? tn_q[2] : en01;
      ext_q <= (tx_q[2] < ex01) ? tx_q[2] : ex01;
      any_miss_q <= fl_q[0][DL+1].miss | fl_q[1][DL+1].miss | fl_q[2][DL+1].miss;
    end
  end

  // final compare
  always_ff @(posedge clk_i) begin
    if (en) hit_q <= !any_miss_q && (ent_q <= ext_q);
  end

  assign out_valid_o = vld_q[LAT-1];
  assign hit_o = hit_q;
endmodule

/* rtl/rbst_checker.sv */
module rbst_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic hit_o
);
  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o))
    else $error("result beat changed under stall");

  // input is stalled only while a result waits on a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // no output stall means input never stalled
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input blocked with free output");
endmodule

bind ray_box_slab_test rbst_checker u_rbst_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .hit_o
);
